// ===== rtl/core/tq_pkg.sv =====
// Shared constants and types for the time-ordered event queue.
// Used by tq_cell and time_ordered_event_queue_top; no dependencies.
package tq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 32;
  localparam int TAG_BITS    = 16;
  localparam int TYPE_BITS   = 2;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  localparam logic [STATUS_BITS-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_POP_EMPTY  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_INSERT_FULL = 2'd2;

  // types below this code are customer events (arrival, leave)
  localparam logic [TYPE_BITS-1:0] TYPE_FIRST_NON_CUSTOMER = 2'd2;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

  function automatic logic is_customer(input logic [TYPE_BITS-1:0] ev_type);
    return ev_type < TYPE_FIRST_NON_CUSTOMER;
  endfunction

endpackage

// ===== rtl/core/tq_cell.sv =====
// One slot of the sorted shift-register queue.
// Depends on tq_pkg (cell_ctrl_t, TYPE_BITS).
module tq_cell #(
  parameter int TIME_BITS = tq_pkg::TIME_BITS,
  parameter int TAG_BITS  = tq_pkg::TAG_BITS
) (
  input  logic                          clk,
  input  tq_pkg::cell_ctrl_t            ctrl,
  input  logic                          occ,
  input  logic [TIME_BITS-1:0]          new_time,
  input  logic [tq_pkg::TYPE_BITS-1:0]  new_type,
  input  logic [TAG_BITS-1:0]           new_tag,
  input  logic                          left_after,
  input  logic [TIME_BITS-1:0]          left_time,
  input  logic [tq_pkg::TYPE_BITS-1:0]  left_type,
  input  logic [TAG_BITS-1:0]           left_tag,
  input  logic [TIME_BITS-1:0]          right_time,
  input  logic [tq_pkg::TYPE_BITS-1:0]  right_type,
  input  logic [TAG_BITS-1:0]           right_tag,
  output logic                          after,
  output logic [TIME_BITS-1:0]          slot_time,
  output logic [tq_pkg::TYPE_BITS-1:0]  slot_type,
  output logic [TAG_BITS-1:0]           slot_tag
);

  // new entry lands at or before this slot
  assign after = !occ || (slot_time > new_time);

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      slot_time <= right_time;
      slot_type <= right_type;
      slot_tag  <= right_tag;
    end else if (ctrl.insert && after) begin
      if (left_after) begin
        slot_time <= left_time;
        slot_type <= left_type;
        slot_tag  <= left_tag;
      end else begin
        slot_time <= new_time;
        slot_type <= new_type;
        slot_tag  <= new_tag;
      end
    end
  end

endmodule

// ===== rtl/core/time_ordered_event_queue_top.sv =====
// Top level of the time-ordered event queue: a row of tq_cell slots,
// entry and customer counters, and the result register. Depends on tq_pkg, tq_cell.
//
//   channel | handshake            | payload
//   req     | req_valid/req_ready  | kind, event_time, event_type, event_tag
//   rsp     | rsp_valid/rsp_ready  | status, popped_*, earliest_time, entry_count,
//           |                      | queue_empty, customer_present
//
// One transfer per cycle while req_ready is high: all slots compare against the
// new time in parallel and shift in the same cycle; the result is registered
// and shown the next cycle. req_ready is low only while a result waits in the
// output register. Reset empties the queue; slot contents are not cleared.
module time_ordered_event_queue_top #(
  parameter int QUEUE_DEPTH = tq_pkg::QUEUE_DEPTH,
  parameter int TIME_BITS   = tq_pkg::TIME_BITS,
  parameter int TAG_BITS    = tq_pkg::TAG_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic                            kind,
  input  logic [TIME_BITS-1:0]            event_time,
  input  logic [tq_pkg::TYPE_BITS-1:0]    event_type,
  input  logic [TAG_BITS-1:0]             event_tag,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [tq_pkg::STATUS_BITS-1:0]  status,
  output logic [TIME_BITS-1:0]            popped_time,
  output logic [tq_pkg::TYPE_BITS-1:0]    popped_type,
  output logic [TAG_BITS-1:0]             popped_tag,
  output logic [TIME_BITS-1:0]            earliest_time,
  output logic [tq_pkg::COUNT_BITS-1:0]   entry_count,
  output logic                            queue_empty,
  output logic                            customer_present
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] cust, cust_next;

  logic [TIME_BITS-1:0]         c_time [QUEUE_DEPTH];
  logic [tq_pkg::TYPE_BITS-1:0] c_type [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]          c_tag  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]       c_after;
  logic [QUEUE_DEPTH-1:0]       occ;

  tq_pkg::cell_ctrl_t ctrl;
  logic accept, full, empty;
  logic [TIME_BITS-1:0] head_next;
  logic [tq_pkg::STATUS_BITS-1:0] status_next;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = count == CW'(QUEUE_DEPTH);
  assign empty     = count == '0;

  assign ctrl.insert = accept && (kind == tq_pkg::KIND_INSERT) && !full;
  assign ctrl.pop    = accept && (kind == tq_pkg::KIND_POP) && !empty;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic                         l_after;
    logic [TIME_BITS-1:0]         l_time, r_time;
    logic [tq_pkg::TYPE_BITS-1:0] l_type, r_type;
    logic [TAG_BITS-1:0]          l_tag, r_tag;

    assign occ[g] = count > CW'(g);

    if (g == 0) begin : g_first
      assign l_after = 1'b0;
      assign l_time  = '0;
      assign l_type  = '0;
      assign l_tag   = '0;
    end else begin : g_mid
      assign l_after = c_after[g-1];
      assign l_time  = c_time[g-1];
      assign l_type  = c_type[g-1];
      assign l_tag   = c_tag[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign r_time = '0;
      assign r_type = '0;
      assign r_tag  = '0;
    end else begin : g_inner
      assign r_time = c_time[g+1];
      assign r_type = c_type[g+1];
      assign r_tag  = c_tag[g+1];
    end

    tq_cell #(
      .TIME_BITS(TIME_BITS),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ[g]),
      .new_time  (event_time),
      .new_type  (event_type),
      .new_tag   (event_tag),
      .left_after(l_after),
      .left_time (l_time),
      .left_type (l_type),
      .left_tag  (l_tag),
      .right_time(r_time),
      .right_type(r_type),
      .right_tag (r_tag),
      .after     (c_after[g]),
      .slot_time (c_time[g]),
      .slot_type (c_type[g]),
      .slot_tag  (c_tag[g])
    );
  end

  always_comb begin
    count_next  = count;
    cust_next   = cust;
    status_next = tq_pkg::STATUS_OK;
    head_next   = empty ? '0 : c_time[0];
    if (kind == tq_pkg::KIND_INSERT) begin
      if (full) begin
        status_next = tq_pkg::STATUS_INSERT_FULL;
      end else begin
        count_next = count + CW'(1);
        if (tq_pkg::is_customer(event_type)) begin
          cust_next = cust + CW'(1);
        end
        if (c_after[0]) begin
          head_next = event_time;
        end
      end
    end else begin
      if (empty) begin
        status_next = tq_pkg::STATUS_POP_EMPTY;
      end else begin
        count_next = count - CW'(1);
        if (tq_pkg::is_customer(c_type[0])) begin
          cust_next = cust - CW'(1);
        end
        head_next = (count > CW'(1)) ? c_time[1] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cust      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        cust      <= cust_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status           <= status_next;
      popped_time      <= ctrl.pop ? c_time[0] : '0;
      popped_type      <= ctrl.pop ? c_type[0] : '0;
      popped_tag       <= ctrl.pop ? c_tag[0] : '0;
      earliest_time    <= head_next;
      entry_count      <= tq_pkg::COUNT_BITS'(count_next);
      queue_empty      <= count_next == '0;
      customer_present <= cust_next != '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond depth");

  a_cust_bound: assert property (@(posedge clk) disable iff (rst)
    cust <= count)
    else $error("customer count exceeds entry count");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (queue_empty == (count == '0)))
    else $error("empty flag disagrees with stored count");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |=> count == $past(count) - CW'(1))
    else $error("pop did not decrement count");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (count > CW'(1)) |-> (c_time[0] <= c_time[1]))
    else $error("head slots out of order");

endmodule
